FILE: rtl/core/dsuf_pkg.sv
package dsuf_pkg;

   localparam int FUNC_W = 3;
   localparam int ELEM_W = 10;
   localparam int RANK_W = 4;

   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   localparam logic [FUNC_W-1:0] FN_FIND  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_UNION = 3'd1;
   localparam logic [FUNC_W-1:0] FN_LINK  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_MAKE  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_INIT  = 3'd4;

   typedef logic [RANK_W-1:0] rank_type;

endpackage

FILE: rtl/core/dsuf_ram.sv
module dsuf_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/disjoint_set_union_find_unit.sv
// Find walks the parent chain to the root, then walks it again from the element, pointing each entry at the root.
// Union runs two finds back to back and then, if the roots differ, one or two link writes.
// Make-set, out-of-range requests and unused codes go straight to the response; init first clears the whole table.
// One request is in flight at a time; the table's one read port walks one entry per cycle.
// Reset starts a clearing pass over all NUM_ELEMENTS entries (1024 by default) with requests stalled.
module disjoint_set_union_find_unit #(
   parameter int NUM_ELEMENTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dsuf_pkg::FUNC_W-1:0]   req_func,
   input  logic [dsuf_pkg::ELEM_W-1:0]   req_elem_a,
   input  logic [dsuf_pkg::ELEM_W-1:0]   req_elem_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsuf_pkg::ELEM_W-1:0]   rsp_root,
   output logic                          rsp_same_set
);

   import dsuf_pkg::*;

   localparam int IDX_W = $clog2(NUM_ELEMENTS);
   localparam int ENT_W = IDX_W + RANK_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_WALK = 4'd2;
   localparam logic [3:0] S_COMP = 4'd3;
   localparam logic [3:0] S_STB  = 4'd4;
   localparam logic [3:0] S_LNKA = 4'd5;
   localparam logic [3:0] S_LNKB = 4'd6;
   localparam logic [3:0] S_JOIN = 4'd7;
   localparam logic [3:0] S_BUMP = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [ELEM_W-1:0] a_ff, a_in;
   logic [ELEM_W-1:0] b_ff, b_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  x_ff, x_in;
   logic              phase_ff, phase_in;
   logic [IDX_W-1:0]  find_root_ff, find_root_in;
   rank_type          find_rank_ff, find_rank_in;
   logic [IDX_W-1:0]  root_a_ff, root_a_in;
   rank_type          rank_a_ff, rank_a_in;
   logic [IDX_W-1:0]  root_b_ff, root_b_in;
   rank_type          rank_b_ff, rank_b_in;
   logic [ELEM_W-1:0] res_root_ff, res_root_in;
   logic              res_same_ff, res_same_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_root_ff, rsp_root_in;
   logic              rsp_same_ff, rsp_same_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [ENT_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;
   logic [ENT_W-1:0]  mem_rdata;
   logic [IDX_W-1:0]  rd_parent;
   rank_type          rd_rank;

   logic              req_a_ok;
   logic              req_b_ok;
   logic [IDX_W-1:0]  req_idx_a;
   logic [IDX_W-1:0]  idx_a_ff;
   logic [IDX_W-1:0]  idx_b_ff;
   logic              fdone;
   logic [IDX_W-1:0]  froot;
   rank_type          frank;
   logic              a_up;
   logic [IDX_W-1:0]  lo_root;
   logic [IDX_W-1:0]  hi_root;
   rank_type          lo_rank;

   dsuf_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_ELEMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_parent = mem_rdata[IDX_W-1:0];
   assign rd_rank   = mem_rdata[ENT_W-1:IDX_W];

   assign req_a_ok  = 32'(req_elem_a) < NUM_ELEMENTS;
   assign req_b_ok  = 32'(req_elem_b) < NUM_ELEMENTS;
   assign req_idx_a = IDX_W'(req_elem_a);
   assign idx_a_ff  = IDX_W'(a_ff);
   assign idx_b_ff  = IDX_W'(b_ff);

   assign a_up    = rank_a_ff > rank_b_ff;
   assign lo_root = a_up ? root_b_ff : root_a_ff;
   assign hi_root = a_up ? root_a_ff : root_b_ff;
   assign lo_rank = a_up ? rank_b_ff : rank_a_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      x_in         = x_ff;
      phase_in     = phase_ff;
      find_root_in = find_root_ff;
      find_rank_in = find_rank_ff;
      root_a_in    = root_a_ff;
      rank_a_in    = rank_a_ff;
      root_b_in    = root_b_ff;
      rank_b_in    = rank_b_ff;
      res_root_in  = res_root_ff;
      res_same_in  = res_same_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_same_in  = rsp_same_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = {rd_rank, find_root_ff};
      mem_raddr    = cur_ff;
      fdone        = 1'b0;
      froot        = find_root_ff;
      frank        = find_rank_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in     = req_func;
               a_in        = req_elem_a;
               b_in        = req_elem_b;
               res_root_in = req_elem_a;
               res_same_in = 1'b0;
               state_in    = S_DONE;
               unique case (req_func)
                  FN_FIND: begin
                     if (req_a_ok) begin
                        mem_raddr = req_idx_a;
                        cur_in    = req_idx_a;
                        x_in      = req_idx_a;
                        phase_in  = 1'b0;
                        state_in  = S_WALK;
                     end
                  end
                  FN_UNION: begin
                     if (req_a_ok && req_b_ok) begin
                        mem_raddr = req_idx_a;
                        cur_in    = req_idx_a;
                        x_in      = req_idx_a;
                        phase_in  = 1'b0;
                        state_in  = S_WALK;
                     end
                  end
                  FN_LINK: begin
                     if (req_a_ok && req_b_ok) begin
                        if (req_elem_a == req_elem_b) begin
                           res_same_in = 1'b1;
                        end else begin
                           mem_raddr = req_idx_a;
                           state_in  = S_LNKA;
                        end
                     end
                  end
                  FN_MAKE: begin
                     if (req_a_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_idx_a;
                        mem_wdata = {{RANK_W{1'b0}}, req_idx_a};
                     end
                  end
                  FN_INIT: begin
                     res_root_in = '0;
                     clr_cnt_in  = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = S_CLR;
                  end
                  default: begin
                     res_root_in = '0;
                  end
               endcase
            end
         end
         S_CLR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = {{RANK_W{1'b0}}, clr_cnt_ff};
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(NUM_ELEMENTS - 1)) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_WALK: begin
            if (rd_parent == cur_ff) begin
               find_root_in = cur_ff;
               find_rank_in = rd_rank;
               if (x_ff == cur_ff) begin
                  fdone = 1'b1;
                  froot = cur_ff;
                  frank = rd_rank;
               end else begin
                  mem_raddr = x_ff;
                  cur_in    = x_ff;
                  state_in  = S_COMP;
               end
            end else begin
               mem_raddr = rd_parent;
               cur_in    = rd_parent;
            end
         end
         S_COMP: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = {rd_rank, find_root_ff};
            if (rd_parent == find_root_ff) begin
               fdone = 1'b1;
            end else begin
               mem_raddr = rd_parent;
               cur_in    = rd_parent;
            end
         end
         S_STB: begin
            mem_raddr = idx_b_ff;
            cur_in    = idx_b_ff;
            x_in      = idx_b_ff;
            state_in  = S_WALK;
         end
         S_LNKA: begin
            if (rd_parent != idx_a_ff) begin
               state_in = S_DONE;
            end else begin
               root_a_in = idx_a_ff;
               rank_a_in = rd_rank;
               mem_raddr = idx_b_ff;
               state_in  = S_LNKB;
            end
         end
         S_LNKB: begin
            if (rd_parent != idx_b_ff) begin
               state_in = S_DONE;
            end else begin
               root_b_in = idx_b_ff;
               rank_b_in = rd_rank;
               state_in  = S_JOIN;
            end
         end
         S_JOIN: begin
            mem_we      = 1'b1;
            mem_waddr   = lo_root;
            mem_wdata   = {lo_rank, hi_root};
            res_root_in = ELEM_W'(hi_root);
            res_same_in = 1'b0;
            if (rank_a_ff == rank_b_ff && rank_b_ff != RANK_MAX) begin
               root_a_in = hi_root;
               rank_a_in = rank_b_ff + RANK_W'(1);
               state_in  = S_BUMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BUMP: begin
            mem_we    = 1'b1;
            mem_waddr = root_a_ff;
            mem_wdata = {rank_a_ff, root_a_ff};
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = res_root_ff;
               rsp_same_in  = res_same_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fdone) begin
         priority if (func_ff == FN_FIND) begin
            res_root_in = ELEM_W'(froot);
            res_same_in = 1'b0;
            state_in    = S_DONE;
         end else if (!phase_ff) begin
            root_a_in = froot;
            rank_a_in = frank;
            phase_in  = 1'b1;
            state_in  = S_STB;
         end else if (froot == root_a_ff) begin
            res_root_in = ELEM_W'(froot);
            res_same_in = 1'b1;
            state_in    = S_DONE;
         end else begin
            root_b_in = froot;
            rank_b_in = frank;
            state_in  = S_JOIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff      <= func_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      cur_ff       <= cur_in;
      x_ff         <= x_in;
      find_root_ff <= find_root_in;
      find_rank_ff <= find_rank_in;
      root_a_ff    <= root_a_in;
      rank_a_ff    <= rank_a_in;
      root_b_ff    <= root_b_in;
      rank_b_ff    <= rank_b_in;
      res_root_ff  <= res_root_in;
      res_same_ff  <= res_same_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_same_ff  <= rsp_same_in;
   end

   assign req_stall    = state_ff != S_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_root     = rsp_root_ff;
   assign rsp_same_set = rsp_same_ff;

   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("Requests must stall during the clearing pass after reset.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && mem_we) |-> (req_valid && req_func == FN_MAKE))
      else $error("Table written from idle by something other than a make-set transfer.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMP) |-> (cur_ff != find_root_ff))
      else $error("Path compression is about to rewrite the root entry.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JOIN) |-> (root_a_ff != root_b_ff))
      else $error("Join attempted on a single root.");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import dsuf_pkg::*;

   localparam int NUM_ELEMENTS = 1024;
   localparam logic [ELEM_W-1:0] ELEM_MAX = '1;
   localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FN_SPARE_LAST = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ELEM_W-1:0] elem_a;
      logic [ELEM_W-1:0] elem_b;
   } request_type;

   typedef struct packed {
      logic [ELEM_W-1:0] root;
      logic              same_set;
   } outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic [ELEM_W-1:0] req_elem_a = '0;
   logic [ELEM_W-1:0] req_elem_b = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ELEM_W-1:0] rsp_root;
   logic              rsp_same_set;

   request_type pending_requests[$];
   outcome_type expected_outcomes[$];
   logic [ELEM_W-1:0] parent_tbl [NUM_ELEMENTS];
   rank_type          rank_tbl [NUM_ELEMENTS];

   bit quiet_mode = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int press_count = 0;
   int press_seen = 0;
   int mismatches = 0;

   disjoint_set_union_find_unit #(
      .NUM_ELEMENTS(NUM_ELEMENTS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_elem_a   (req_elem_a),
      .req_elem_b   (req_elem_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_root     (rsp_root),
      .rsp_same_set (rsp_same_set)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_table();
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
         parent_tbl[i] = ELEM_W'(i);
         rank_tbl[i] = '0;
      end
   endfunction

   function automatic logic [ELEM_W-1:0] walk_and_compress(input logic [ELEM_W-1:0] x);
      logic [ELEM_W-1:0] r;
      logic [ELEM_W-1:0] cur;
      logic [ELEM_W-1:0] nxt;
      int steps;
      r = x;
      steps = 0;
      while (parent_tbl[r] != r && steps < NUM_ELEMENTS) begin
         r = parent_tbl[r];
         steps++;
      end
      cur = x;
      steps = 0;
      while (cur != r && steps < NUM_ELEMENTS) begin
         nxt = parent_tbl[cur];
         parent_tbl[cur] = r;
         cur = nxt;
         steps++;
      end
      return r;
   endfunction

   function automatic logic [ELEM_W-1:0] hang_root(input logic [ELEM_W-1:0] x,
                                                   input logic [ELEM_W-1:0] y);
      logic [ELEM_W-1:0] lo;
      logic [ELEM_W-1:0] hi;
      if (rank_tbl[x] > rank_tbl[y]) begin
         lo = y;
         hi = x;
      end else begin
         lo = x;
         hi = y;
      end
      if (rank_tbl[lo] == rank_tbl[hi] && rank_tbl[hi] < RANK_MAX)
         rank_tbl[hi] = rank_tbl[hi] + 1'b1;
      parent_tbl[lo] = hi;
      return hi;
   endfunction

   function automatic outcome_type apply_request(input request_type rq);
      outcome_type res;
      logic [ELEM_W-1:0] ra;
      logic [ELEM_W-1:0] rb;
      res = '0;
      case (rq.func)
         FN_FIND: res.root = walk_and_compress(rq.elem_a);
         FN_UNION: begin
            ra = walk_and_compress(rq.elem_a);
            rb = walk_and_compress(rq.elem_b);
            if (ra == rb) begin
               res.root = ra;
               res.same_set = 1'b1;
            end else begin
               res.root = hang_root(ra, rb);
            end
         end
         FN_LINK: begin
            res.root = rq.elem_a;
            if (rq.elem_a == rq.elem_b)
               res.same_set = 1'b1;
            else if (parent_tbl[rq.elem_a] == rq.elem_a && parent_tbl[rq.elem_b] == rq.elem_b)
               res.root = hang_root(rq.elem_a, rq.elem_b);
         end
         FN_MAKE: begin
            parent_tbl[rq.elem_a] = rq.elem_a;
            rank_tbl[rq.elem_a] = '0;
            res.root = rq.elem_a;
         end
         FN_INIT: clear_table();
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [ELEM_W-1:0] top_of(input logic [ELEM_W-1:0] e);
      logic [ELEM_W-1:0] r;
      r = e;
      for (int k = 0; k < NUM_ELEMENTS && parent_tbl[r] != r; k++)
         r = parent_tbl[r];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ELEM_W-1:0] pick_elem(input int base, input int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 88)
         return ELEM_W'(base + $urandom_range(0, span - 1));
      if (r < 94)
         return $urandom_range(0, 1) ? ELEM_MAX : '0;
      return ELEM_W'($urandom);
   endfunction

   function automatic void flag_error(input string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
   endfunction

   task automatic enqueue(input logic [FUNC_W-1:0] f, input logic [ELEM_W-1:0] a,
                          input logic [ELEM_W-1:0] b);
      while (pending_requests.size() > 4)
         @(negedge clock);
      pending_requests.push_back('{func: f, elem_a: a, elem_b: b});
   endtask

   always @(posedge clock) begin : drive_proc
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         req_func <= '0;
         req_elem_a <= '0;
         req_elem_b <= '0;
         send_gap = 0;
         clear_table();
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            expected_outcomes.push_back(apply_request('{func: req_func, elem_a: req_elem_a,
                                                        elem_b: req_elem_b}));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_func <= next_req.func;
            req_elem_a <= next_req.elem_a;
            req_elem_b <= next_req.elem_b;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_proc
      outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               flag_error($sformatf("result transfer with none expected, got root %0d same_set %0d",
                                    rsp_root, rsp_same_set));
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_root !== want.root)
                  flag_error($sformatf("root expected %0d, got %0d", want.root, rsp_root));
               if (rsp_same_set !== want.same_set)
                  flag_error($sformatf("same_set expected %0d, got %0d", want.same_set,
                                       rsp_same_set));
            end
         end
         if (press_seen != press_count) begin
            press_seen = press_count;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #(200_000_000);
      $display("tb_top failed");
      $finish;
   end

   initial begin : stimulus_proc
      int r;
      int base;
      int span;
      int slot [17];
      int spare [$];
      int carry;
      int lvl;
      int big;
      int p;
      int q;
      logic [FUNC_W-1:0] f;
      logic [ELEM_W-1:0] a;
      logic [ELEM_W-1:0] b;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      enqueue(FN_FIND, '0, ELEM_MAX);
      enqueue(FN_FIND, ELEM_MAX, '0);
      enqueue(FN_LINK, '0, ELEM_MAX);
      enqueue(FN_UNION, 10'd5, '0);
      enqueue(FN_UNION, '0, 10'd5);
      enqueue(FN_LINK, 10'd7, 10'd7);
      enqueue(FN_LINK, '0, 10'd8);
      enqueue(FN_LINK, 10'd8, '0);
      enqueue(FN_MAKE, ELEM_MAX, '0);
      enqueue(FN_FIND, '0, '0);
      enqueue(FN_UNION, 10'd10, 10'd11);
      enqueue(FN_UNION, 10'd12, 10'd13);
      enqueue(FN_UNION, 10'd10, 10'd12);
      enqueue(FN_FIND, 10'd10, '0);
      enqueue(FN_LINK, 10'd13, 10'd21);
      enqueue(FN_LINK, 10'd22, 10'd13);
      enqueue(FN_UNION, 10'h2AA, 10'h155);
      enqueue(FN_FIND, 10'h155, 10'h2AA);
      enqueue(FN_MAKE, '0, ELEM_MAX);
      for (int k = FN_SPARE_FIRST; k <= FN_SPARE_LAST; k++)
         enqueue(FUNC_W'(k), ELEM_MAX, ELEM_MAX);
      enqueue(FN_INIT, '0, '0);
      enqueue(FN_FIND, 10'd10, '0);

      for (int seg = 0; seg < 13; seg++) begin
         quiet_mode = ($urandom_range(0, 4) == 0);
         span = 1 << $urandom_range(3, 7);
         base = $urandom_range(0, NUM_ELEMENTS - 1);
         // The receiver holds off for a long stretch while requests keep coming.
         if (seg == 5)
            press_count++;
         for (int k = 0; k < 100; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
               f = FN_FIND;
            else if (r < 58)
               f = FN_UNION;
            else if (r < 78)
               f = FN_LINK;
            else if (r < 92)
               f = FN_MAKE;
            else if (r < 93)
               f = FN_INIT;
            else
               f = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
            a = pick_elem(base, span);
            b = pick_elem(base, span);
            if (f == FN_LINK) begin
               if ($urandom_range(0, 3) != 0)
                  a = top_of(a);
               if ($urandom_range(0, 3) != 0)
                  b = top_of(b);
            end
            enqueue(f, a, b);
         end
      end

      // Ranks are built up like a binary counter, and the surviving root is then
      // linked with a low rank root.
      quiet_mode = 1'b1;
      enqueue(FN_INIT, '0, '0);
      for (int i = 0; i < 17; i++)
         slot[i] = -1;
      for (int i = 0; i < 32; i++)
         spare.push_back(900 + i);
      repeat (1 << 5) begin
         carry = spare.pop_front();
         enqueue(FN_MAKE, ELEM_W'(carry), '0);
         lvl = 0;
         while (slot[lvl] >= 0) begin
            enqueue(FN_LINK, ELEM_W'(carry), ELEM_W'(slot[lvl]));
            spare.push_back(carry);
            carry = slot[lvl];
            slot[lvl] = -1;
            lvl++;
         end
         slot[lvl] = carry;
      end
      big = slot[5];
      p = spare.pop_front();
      q = spare.pop_front();
      enqueue(FN_MAKE, ELEM_W'(p), '0);
      enqueue(FN_MAKE, ELEM_W'(q), '0);
      enqueue(FN_LINK, ELEM_W'(p), ELEM_W'(q));
      enqueue(FN_LINK, ELEM_W'(big), ELEM_W'(q));
      enqueue(FN_FIND, ELEM_W'(p), '0);
      enqueue(FN_UNION, ELEM_W'(p), ELEM_W'(big));

      while (pending_requests.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
